// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and codes for the three-wire serial master.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW = 16;

  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE_SETUP = 2'd1;

  localparam logic [CountW-1:0] HALF_PERIOD_RESET = 16'd2;
  localparam logic [CountW-1:0] ENABLE_SETUP_RESET = 16'd4;

  localparam logic [1:0] REQ_IDLE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SETUP = 6'b000010,
    PH_WLOW  = 6'b000100,
    PH_WHIGH = 6'b001000,
    PH_RHIGH = 6'b010000,
    PH_RLOW  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic       end_frame;
    logic       io_in;
  } req_t;

  typedef struct packed {
    logic       ce_pin;
    logic       sclk_pin;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

endpackage

// ===== rtl/tws_if.sv =====
// ----------------------------------------------------------------------------
// tws_if
// Request, result and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface tws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] byte_value;
  logic       end_frame;
  logic       io_in;
  modport source (output valid, req_type, byte_value, end_frame, io_in, input ready);
  modport sink (input valid, req_type, byte_value, end_frame, io_in, output ready);
endinterface

interface tws_res_if;
  logic       valid;
  logic       ready;
  logic       ce_pin;
  logic       sclk_pin;
  logic       io_out;
  logic       io_drive;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       rejected;
  modport source (output valid, ce_pin, sclk_pin, io_out, io_drive, busy_res, read_valid,
                  read_byte, rejected, input ready);
  modport sink (input valid, ce_pin, sclk_pin, io_out, io_drive, busy_res, read_valid,
                read_byte, rejected, output ready);
endinterface

interface tws_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tws_pkg::CfgIdxW-1:0]   index;
  logic [tws_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/three_wire_serial_master_core.sv =====
// ----------------------------------------------------------------------------
// three_wire_serial_master_core
// Tick-driven master for a chip enable / clock / data three-wire link.
// ----------------------------------------------------------------------------
// Every request on in_if is one time tick. It may start a frame and send a
// command byte, write a data byte, read a byte, or do nothing, and it yields
// exactly one result on out_if: the pin levels after that tick, the busy
// flag, a completed read byte and a reject flag.
// The state advances at the accepting edge and the result is registered in
// the output buffer at that edge. One request is accepted every cycle while
// in_if holds ready; the combinational next-state logic in tws_step sets
// that figure.
// When the receiver stalls, a skid stage holds one more result, and in_if
// drops ready only when both result slots are full, so no result is lost.
// cfg_if writes the half-period count (index 0) and the enable setup count
// (index 1); it is always ready and is meant to be used while idle.
// Synchronous reset puts the link idle with all pins low, the data line
// released, and the counts at their defaults of 2 and 4 ticks.
// ----------------------------------------------------------------------------
module three_wire_serial_master_core (
  input  logic  clk,
  input  logic  rst_n,
  tws_req_if.sink   in_if,
  tws_res_if.source out_if,
  tws_cfg_if.sink   cfg_if
);

  tws_pkg::req_t req;
  tws_pkg::res_t step_res, out_res;
  logic          accept;

  // Requests advance the link only when the output side can take the result.
  assign accept = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    req.req_type   = in_if.req_type;
    req.byte_value = in_if.byte_value;
    req.end_frame  = in_if.end_frame;
    req.io_in      = in_if.io_in;
  end

  tws_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (accept),
    .req      (req),
    .cfg_we   (cfg_if.valid),
    .cfg_idx  (cfg_if.index),
    .cfg_data (cfg_if.data),
    .res      (step_res)
  );

  tws_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_if.valid),
    .push_ready (in_if.ready),
    .push_data  (step_res),
    .pop_valid  (out_if.valid),
    .pop_ready  (out_if.ready),
    .pop_data   (out_res)
  );

  // Result fields are unpacked onto the interface by name.
  assign out_if.ce_pin     = out_res.ce_pin;
  assign out_if.sclk_pin   = out_res.sclk_pin;
  assign out_if.io_out     = out_res.io_out;
  assign out_if.io_drive   = out_res.io_drive;
  assign out_if.busy_res   = out_res.busy_res;
  assign out_if.read_valid = out_res.read_valid;
  assign out_if.read_byte  = out_res.read_byte;
  assign out_if.rejected   = out_res.rejected;

endmodule

// ===== rtl/tws_step.sv =====
// ----------------------------------------------------------------------------
// tws_step
// Link state registers and the one-tick next-state logic.
// ----------------------------------------------------------------------------
module tws_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  tws_pkg::req_t                req,
  input  logic                         cfg_we,
  input  logic [tws_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [tws_pkg::CfgDataW-1:0] cfg_data,
  output tws_pkg::res_t                res
);

  logic [tws_pkg::CountW-1:0] half_r, setup_r;
  tws_pkg::phase_t            phase_r, phase_nxt;
  logic [tws_pkg::CountW-1:0] wait_r, wait_nxt;
  logic [2:0]                 bit_r, bit_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic                       frame_r, frame_nxt;
  logic                       close_r, close_nxt;
  logic                       ce_r, ce_nxt, sclk_r, sclk_nxt;
  logic                       io_r, io_nxt, drv_r, drv_nxt;
  logic [tws_pkg::CountW-1:0] hp, wc;
  logic                       rej, valid;

  // A zero count behaves as one.
  assign hp = (half_r == '0) ? tws_pkg::CountW'(1) : half_r;
  assign wc = wait_r - tws_pkg::CountW'(1);

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    frame_nxt = frame_r;
    close_nxt = close_r;
    ce_nxt    = ce_r;
    sclk_nxt  = sclk_r;
    io_nxt    = io_r;
    drv_nxt   = drv_r;
    rej       = 1'b0;
    valid     = 1'b0;
    if (phase_r != tws_pkg::PH_IDLE) begin
      rej      = (req.req_type != tws_pkg::REQ_IDLE);
      wait_nxt = wc;
      if (wc == '0) begin
        case (phase_r)
          tws_pkg::PH_SETUP: begin
            bit_nxt   = '0;
            drv_nxt   = 1'b1;
            io_nxt    = shift_r[0];
            sclk_nxt  = 1'b0;
            wait_nxt  = hp;
            phase_nxt = tws_pkg::PH_WLOW;
          end
          tws_pkg::PH_WLOW: begin
            sclk_nxt  = 1'b1;
            wait_nxt  = hp;
            phase_nxt = tws_pkg::PH_WHIGH;
          end
          tws_pkg::PH_WHIGH: begin
            shift_nxt = {1'b0, shift_r[7:1]};
            if (bit_r == tws_pkg::LAST_BIT) begin
              phase_nxt = tws_pkg::PH_IDLE;
              wait_nxt  = '0;
              if (close_r) begin
                sclk_nxt  = 1'b0;
                ce_nxt    = 1'b0;
                frame_nxt = 1'b0;
                close_nxt = 1'b0;
              end
            end else begin
              bit_nxt   = bit_r + 3'd1;
              drv_nxt   = 1'b1;
              io_nxt    = shift_r[1];
              sclk_nxt  = 1'b0;
              wait_nxt  = hp;
              phase_nxt = tws_pkg::PH_WLOW;
            end
          end
          tws_pkg::PH_RHIGH: begin
            sclk_nxt  = 1'b0;
            wait_nxt  = hp;
            phase_nxt = tws_pkg::PH_RLOW;
          end
          tws_pkg::PH_RLOW: begin
            shift_nxt = {req.io_in, shift_r[7:1]};
            if (bit_r == tws_pkg::LAST_BIT) begin
              valid     = 1'b1;
              phase_nxt = tws_pkg::PH_IDLE;
              wait_nxt  = '0;
              if (close_r) begin
                sclk_nxt  = 1'b0;
                ce_nxt    = 1'b0;
                frame_nxt = 1'b0;
                close_nxt = 1'b0;
              end
            end else begin
              bit_nxt   = bit_r + 3'd1;
              drv_nxt   = 1'b0;
              sclk_nxt  = 1'b1;
              wait_nxt  = hp;
              phase_nxt = tws_pkg::PH_RHIGH;
            end
          end
          default: begin
            phase_nxt = tws_pkg::PH_IDLE;
            wait_nxt  = '0;
          end
        endcase
      end
    end else begin
      case (req.req_type)
        tws_pkg::REQ_START: begin
          sclk_nxt  = 1'b0;
          ce_nxt    = 1'b1;
          frame_nxt = 1'b1;
          close_nxt = req.end_frame;
          shift_nxt = req.byte_value;
          bit_nxt   = '0;
          wait_nxt  = (setup_r == '0) ? tws_pkg::CountW'(1) : setup_r;
          phase_nxt = tws_pkg::PH_SETUP;
        end
        tws_pkg::REQ_WRITE: begin
          if (!frame_r) begin
            rej = 1'b1;
          end else begin
            close_nxt = req.end_frame;
            bit_nxt   = '0;
            shift_nxt = req.byte_value;
            drv_nxt   = 1'b1;
            io_nxt    = req.byte_value[0];
            sclk_nxt  = 1'b0;
            wait_nxt  = hp;
            phase_nxt = tws_pkg::PH_WLOW;
          end
        end
        tws_pkg::REQ_READ: begin
          if (!frame_r) begin
            rej = 1'b1;
          end else begin
            close_nxt = req.end_frame;
            bit_nxt   = '0;
            shift_nxt = '0;
            drv_nxt   = 1'b0;
            sclk_nxt  = 1'b1;
            wait_nxt  = hp;
            phase_nxt = tws_pkg::PH_RHIGH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.ce_pin     = ce_nxt;
    res.sclk_pin   = sclk_nxt;
    res.io_out     = io_nxt;
    res.io_drive   = drv_nxt;
    res.busy_res   = (phase_nxt != tws_pkg::PH_IDLE);
    res.read_valid = valid;
    res.read_byte  = valid ? shift_nxt : 8'd0;
    res.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= tws_pkg::HALF_PERIOD_RESET;
      setup_r <= tws_pkg::ENABLE_SETUP_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == tws_pkg::CFG_HALF_PERIOD) begin
        half_r <= cfg_data;
      end else if (cfg_idx == tws_pkg::CFG_ENABLE_SETUP) begin
        setup_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tws_pkg::PH_IDLE;
      wait_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      frame_r <= 1'b0;
      close_r <= 1'b0;
      ce_r    <= 1'b0;
      sclk_r  <= 1'b0;
      io_r    <= 1'b0;
      drv_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      frame_r <= frame_nxt;
      close_r <= close_nxt;
      ce_r    <= ce_nxt;
      sclk_r  <= sclk_nxt;
      io_r    <= io_nxt;
      drv_r   <= drv_nxt;
    end
  end

endmodule

// ===== rtl/tws_outbuf.sv =====
// ----------------------------------------------------------------------------
// tws_outbuf
// Result register with a skid stage, so a stalled receiver costs no ticks.
// ----------------------------------------------------------------------------
module tws_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tws_pkg::res_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tws_pkg::res_t pop_data
);

  logic          main_v_r, skid_v_r;
  tws_pkg::res_t main_r, skid_r;
  logic          push, pop;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && !skid_v_r;
  assign pop        = main_v_r && pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r) begin
      main_v_r <= push;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || (pop && !skid_v_r)) begin
      main_r <= push_data;
    end else if (pop) begin
      main_r <= skid_r;
    end
    if (main_v_r && !pop && push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ===== tb/three_wire_serial_master_core_tb.sv =====
// ----------------------------------------------------------------------------
// three_wire_serial_master_core_tb
// Self-checking testbench for the three-wire serial master core.
// Every request on the input channel is one time tick. A local model of
// the link predicts the pin levels, busy, read and reject flags of each
// tick, and the monitor checks every result against it field by field.
// The run covers frames, writes, reads, rejected requests and a range of
// clock and enable setup counts, with random stalls on both channels.
// ----------------------------------------------------------------------------
module three_wire_serial_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;

  // How the data line is filled on the ticks that the generator queues.
  localparam int IO_LOW  = 0;
  localparam int IO_HIGH = 1;
  localparam int IO_RAND = 2;

  // Only this many mismatches are printed; later ones are just counted.
  localparam int REPORT_LIMIT = 10;
  // Upper bound on queued ticks.
  localparam int QUEUE_CAP = 2048;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tws_req_if in_ch();
  tws_res_if out_ch();
  tws_cfg_if cfg_ch();

  three_wire_serial_master_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Link model. It holds its own copy of the two counts and of the link
  // state, and is advanced once for each request that the core accepts.
  // --------------------------------------------------------------------------
  logic [CfgDataW-1:0] cfg_half = HALF_PERIOD_RESET;
  logic [CfgDataW-1:0] cfg_setup = ENABLE_SETUP_RESET;

  phase_t      lk_phase = PH_IDLE;
  logic [15:0] lk_wait = '0;
  logic [2:0]  lk_bit = '0;
  logic [7:0]  lk_shift = '0;
  logic        lk_open = 1'b0;
  logic        lk_close = 1'b0;
  logic        pin_ce = 1'b0;
  logic        pin_sclk = 1'b0;
  logic        pin_io = 1'b0;
  logic        pin_drv = 1'b0;

  function automatic void reset_link_model();
    cfg_half = HALF_PERIOD_RESET;
    cfg_setup = ENABLE_SETUP_RESET;
    lk_phase = PH_IDLE;
    lk_wait = '0;
    lk_bit = '0;
    lk_shift = '0;
    lk_open = 1'b0;
    lk_close = 1'b0;
    pin_ce = 1'b0;
    pin_sclk = 1'b0;
    pin_io = 1'b0;
    pin_drv = 1'b0;
  endfunction

  // A count of zero behaves as a count of one.
  function automatic logic [15:0] half_ticks();
    return (cfg_half == '0) ? 16'd1 : cfg_half;
  endfunction

  // A written bit: data set and clock low for one half period.
  function automatic void begin_write_bit();
    pin_drv = 1'b1;
    pin_io = lk_shift[0];
    pin_sclk = 1'b0;
    lk_wait = half_ticks();
    lk_phase = PH_WLOW;
  endfunction

  // A read bit: line released and clock high for one half period.
  function automatic void begin_read_bit();
    pin_drv = 1'b0;
    pin_sclk = 1'b1;
    lk_wait = half_ticks();
    lk_phase = PH_RHIGH;
  endfunction

  // End of a byte. A pending close drops clock and enable, but the data
  // line keeps its level and drive state.
  function automatic void finish_byte();
    lk_phase = PH_IDLE;
    lk_wait = '0;
    if (lk_close) begin
      pin_sclk = 1'b0;
      pin_ce = 1'b0;
      lk_open = 1'b0;
      lk_close = 1'b0;
    end
  endfunction

  // One tick of a running phase; returns 1 when a read byte completes.
  function automatic bit advance_link(logic io);
    lk_wait = lk_wait - 16'd1;
    if (lk_wait != '0) return 1'b0;
    case (lk_phase)
      PH_SETUP: begin
        lk_bit = '0;
        begin_write_bit();
      end
      PH_WLOW: begin
        pin_sclk = 1'b1;
        lk_wait = half_ticks();
        lk_phase = PH_WHIGH;
      end
      PH_WHIGH: begin
        lk_shift = lk_shift >> 1;
        if (lk_bit == LAST_BIT) begin
          finish_byte();
        end else begin
          lk_bit = lk_bit + 3'd1;
          begin_write_bit();
        end
      end
      PH_RHIGH: begin
        pin_sclk = 1'b0;
        lk_wait = half_ticks();
        lk_phase = PH_RLOW;
      end
      PH_RLOW: begin
        // Sample after the low half; the first bit lands in bit 0.
        lk_shift = {io, lk_shift[7:1]};
        if (lk_bit == LAST_BIT) begin
          finish_byte();
          return 1'b1;
        end
        lk_bit = lk_bit + 3'd1;
        begin_read_bit();
      end
      default: begin
        lk_phase = PH_IDLE;
        lk_wait = '0;
      end
    endcase
    return 1'b0;
  endfunction

  // Pin levels and flags that the core should report after one tick.
  function automatic res_t predict_tick(req_t r);
    res_t o;
    bit   rej;
    bit   done;
    rej = 1'b0;
    done = 1'b0;
    if (lk_phase != PH_IDLE) begin
      // Any request during a running phase is refused, but the phase
      // still moves on by one tick.
      rej = (r.req_type != REQ_IDLE);
      done = advance_link(r.io_in);
    end else if (r.req_type == REQ_START) begin
      // A start is taken even with a frame already open: it restarts it.
      pin_sclk = 1'b0;
      pin_ce = 1'b1;
      lk_open = 1'b1;
      lk_close = r.end_frame;
      lk_shift = r.byte_value;
      lk_bit = '0;
      lk_wait = (cfg_setup == '0) ? 16'd1 : cfg_setup;
      lk_phase = PH_SETUP;
    end else if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
      if (!lk_open) begin
        rej = 1'b1;
      end else begin
        lk_close = r.end_frame;
        lk_bit = '0;
        if (r.req_type == REQ_WRITE) begin
          lk_shift = r.byte_value;
          begin_write_bit();
        end else begin
          lk_shift = '0;
          begin_read_bit();
        end
      end
    end
    o.ce_pin = pin_ce;
    o.sclk_pin = pin_sclk;
    o.io_out = pin_io;
    o.io_drive = pin_drv;
    o.busy_res = (lk_phase != PH_IDLE);
    o.read_valid = done;
    o.read_byte = done ? lk_shift : 8'h00;
    o.rejected = rej;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Queues, counters and idling controls.
  // --------------------------------------------------------------------------
  req_t tick_q[$];         // ticks waiting to be offered to the core
  res_t expected_pins[$];  // predicted results, oldest first

  int send_idle_pct = 29;
  int recv_idle_pct = 67;
  int hold_left = 0;       // cycles the receiver still holds off
  bit req_taken = 1'b0;    // a request was accepted at the last rising edge

  int mismatches = 0;
  int results_seen = 0;
  int reqs_queued = 0;     // non-idle requests handed to the driver
  int rejects_seen = 0;
  int reads_seen = 0;

  req_t drive_item;
  req_t taken_item;
  res_t want;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_IDLE;
    in_ch.byte_value = '0;
    in_ch.end_frame = 1'b0;
    in_ch.io_in = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_HALF_PERIOD;
    cfg_ch.data = '0;
  end

  // --------------------------------------------------------------------------
  // Driver: moves to the next queued tick at the falling edge once the
  // current one has been accepted, or idles at random. A request that is
  // offered stays on the channel until the core takes it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = tick_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= drive_item.req_type;
        in_ch.byte_value <= drive_item.byte_value;
        in_ch.end_frame <= drive_item.end_frame;
        in_ch.io_in <= drive_item.io_in;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, checks a delivered result against the
  // oldest prediction, then runs the model for an accepted request.
  // --------------------------------------------------------------------------
  function automatic void check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("  mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_link_model();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pins.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("  result %0d arrived with no request outstanding", results_seen);
        end else begin
          want = expected_pins.pop_front();
          check_field("ce_pin", 8'(want.ce_pin), 8'(out_ch.ce_pin));
          check_field("sclk_pin", 8'(want.sclk_pin), 8'(out_ch.sclk_pin));
          check_field("io_out", 8'(want.io_out), 8'(out_ch.io_out));
          check_field("io_drive", 8'(want.io_drive), 8'(out_ch.io_drive));
          check_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
          check_field("read_valid", 8'(want.read_valid), 8'(out_ch.read_valid));
          check_field("read_byte", want.read_byte, out_ch.read_byte);
          check_field("rejected", 8'(want.rejected), 8'(out_ch.rejected));
        end
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        taken_item.req_type = in_ch.req_type;
        taken_item.byte_value = in_ch.byte_value;
        taken_item.end_frame = in_ch.end_frame;
        taken_item.io_in = in_ch.io_in;
        want = predict_tick(taken_item);
        if (want.rejected) rejects_seen++;
        if (want.read_valid) reads_seen++;
        expected_pins.push_back(want);
        req_taken = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic logic io_bit(int mode);
    if (mode == IO_LOW) return 1'b0;
    if (mode == IO_HIGH) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  // Ticks that a request keeps the link busy after the tick it arrives on.
  function automatic int busy_span(logic [1:0] kind);
    int half;
    int setup;
    half = (cfg_half == '0) ? 1 : int'(cfg_half);
    setup = (cfg_setup == '0) ? 1 : int'(cfg_setup);
    return (kind == REQ_START ? setup : 0) + 16 * half;
  endfunction

  task automatic push_tick(logic [1:0] kind, logic [7:0] value, logic endf, logic io);
    req_t t;
    t.req_type = kind;
    t.byte_value = value;
    t.end_frame = endf;
    t.io_in = io;
    while (tick_q.size() >= QUEUE_CAP) @(posedge clk);
    tick_q.push_back(t);
    if (kind != REQ_IDLE) reqs_queued++;
  endtask

  // Idle ticks carry random byte and end fields, which the core ignores.
  task automatic idle_ticks(int n, int mode);
    for (int i = 0; i < n; i++)
      push_tick(REQ_IDLE, 8'($urandom), 1'($urandom_range(1)), io_bit(mode));
  endtask

  // A byte request followed by just enough ticks to finish it, so that the
  // next request finds the link idle. With stray set, one of those ticks
  // carries a request instead, which the core has to refuse.
  task automatic byte_req(logic [1:0] kind, logic [7:0] value, logic endf, int mode,
                          bit stray);
    int span;
    int slot;
    span = busy_span(kind);
    slot = stray ? int'($urandom_range(span - 1)) : -1;
    push_tick(kind, value, endf, io_bit(mode));
    for (int i = 0; i < span; i++) begin
      if (i == slot)
        push_tick(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(1)),
                  io_bit(mode));
      else
        push_tick(REQ_IDLE, 8'($urandom), 1'($urandom_range(1)), io_bit(mode));
    end
  endtask

  // The sender pauses here until every predicted result has come back. If
  // the link is still inside a byte, idle ticks are added until it is done,
  // so that the counts may be rewritten.
  task automatic drain_link();
    forever begin
      while (tick_q.size() != 0 || in_ch.valid || expected_pins.size() != 0)
        @(posedge clk);
      if (lk_phase == PH_IDLE) break;
      idle_ticks(1, IO_RAND);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_HALF_PERIOD) cfg_half = value;
    else if (idx == CFG_ENABLE_SETUP) cfg_setup = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed frames (start, one to four data bytes, the last one
  // closing), with stray requests on busy ticks; the rest is random noise
  // followed by enough idle ticks to let any started byte finish.
  task automatic run_random(int count);
    int   goal;
    int   nbytes;
    bit   last;
    logic endf;
    goal = reqs_queued + count;
    while (reqs_queued < goal) begin
      if ($urandom_range(99) < 75) begin
        byte_req(REQ_START, 8'($urandom), 1'b0, IO_RAND, $urandom_range(99) < 15);
        nbytes = $urandom_range(1, 4);
        for (int k = 0; k < nbytes; k++) begin
          last = (k == nbytes - 1);
          // Now and then a frame is left open for a later start to restart.
          endf = last && ($urandom_range(9) != 0);
          byte_req($urandom_range(1) ? REQ_WRITE : REQ_READ, 8'($urandom), endf,
                   IO_RAND, $urandom_range(99) < 15);
          if ($urandom_range(3) == 0) idle_ticks($urandom_range(1, 3), IO_RAND);
        end
      end else begin
        nbytes = $urandom_range(1, 5);
        for (int k = 0; k < nbytes; k++)
          push_tick(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)),
                    io_bit(IO_RAND));
        idle_ticks(busy_span(REQ_START) + 1, IO_RAND);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset counts (half period 2, enable setup 4).
    idle_ticks(2, IO_RAND);
    // Data requests with no frame open are refused.
    push_tick(REQ_WRITE, 8'hFF, 1'b1, 1'b1);
    push_tick(REQ_READ, 8'h00, 1'b0, 1'b0);
    // Extreme command and data bytes, and reads of all ones and all zeros.
    byte_req(REQ_START, 8'h00, 1'b0, IO_LOW, 1'b0);
    byte_req(REQ_WRITE, 8'hFF, 1'b0, IO_HIGH, 1'b0);
    byte_req(REQ_READ, 8'h00, 1'b0, IO_HIGH, 1'b0);
    byte_req(REQ_READ, 8'hA5, 1'b0, IO_LOW, 1'b0);
    // Start while a frame is open restarts it; a stray request is refused.
    byte_req(REQ_START, 8'h5A, 1'b0, IO_RAND, 1'b1);
    // A request on the very last busy tick of a byte is still refused.
    push_tick(REQ_WRITE, 8'h3C, 1'b0, io_bit(IO_RAND));
    idle_ticks(busy_span(REQ_WRITE) - 1, IO_RAND);
    push_tick(REQ_READ, 8'h00, 1'b0, 1'b1);
    // A read that closes the frame, then a write with the frame closed.
    byte_req(REQ_READ, 8'h00, 1'b1, IO_RAND, 1'b0);
    push_tick(REQ_WRITE, 8'h81, 1'b0, 1'b0);
    // A start that closes right after its command byte.
    byte_req(REQ_START, 8'hC3, 1'b1, IO_RAND, 1'b0);
    // Idle tick with every other field set, then a start and a write that closes.
    push_tick(REQ_IDLE, 8'hFF, 1'b1, 1'b1);
    byte_req(REQ_START, 8'h96, 1'b0, IO_RAND, 1'b0);
    byte_req(REQ_WRITE, 8'h81, 1'b1, IO_RAND, 1'b0);
    drain_link();

    // Counts of zero, which act as one.
    write_cfg(CFG_HALF_PERIOD, 16'd0);
    write_cfg(CFG_ENABLE_SETUP, 16'd0);
    run_random(6);
    drain_link();

    // Swap the stall rates of the two sides.
    send_idle_pct = 67;
    recv_idle_pct = 29;
    write_cfg(CFG_HALF_PERIOD, 16'd1);
    write_cfg(CFG_ENABLE_SETUP, 16'd2);
    run_random(6);
    drain_link();

    // No idling from here on. The receiver holds off for a long stretch
    // while the sender keeps offering, so the core fills and stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_HALF_PERIOD, 16'd1);
    write_cfg(CFG_ENABLE_SETUP, 16'd1);
    run_random(6);
    @(posedge clk);
    hold_left = 200;
    drain_link();

    $display("Checked %0d ticks carrying %0d requests: %0d refused, %0d bytes read back.",
             results_seen, reqs_queued, rejects_seen, reads_seen);
    $display("Half periods of zero to two and enable setups of zero to four ticks, under %s",
             "both stall mixes and with none.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far above the longest correct run.
  initial begin
    #400_000;
    $display("Timed out with %0d results still outstanding.", expected_pins.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tws_pkg.sv
rtl/tws_if.sv
rtl/tws_step.sv
rtl/tws_outbuf.sv
rtl/three_wire_serial_master_core.sv
tb/three_wire_serial_master_core_tb.sv
